// ----- sv/ihcs_pkg.sv -----
// ihcs_pkg: shared constants for the item histogram coverage statistics block
// command codes, default sizes and fixed-point constants; no dependencies
package ihcs_pkg;

	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int COUNT_BITS_DEF = 24;

	localparam int CMD_W     = 1;
	localparam int ID_W      = 10;
	localparam int ICNT_W    = 11;
	localparam int COV_W     = 11;
	localparam int RATIO_W   = 17;
	localparam int ENT_W     = 19;
	localparam int GINI_W    = 17;

	localparam logic [CMD_W-1:0]  CMD_COUNT  = 1'b0;
	localparam logic [CMD_W-1:0]  CMD_FINISH = 1'b1;

	localparam logic [ICNT_W-1:0] ITEM_COUNT_RESET = 11'd1024;

	localparam int          LOG_FRAC = 26;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;
	localparam logic [ENT_W-1:0]  ENT_MAX  = 19'h7FFFF;
	localparam logic [GINI_W-1:0] GINI_ONE = 17'h10000;
	localparam logic [COV_W-1:0]  COV_MAX  = 11'h7FF;

endpackage

// ----- sv/item_histogram_coverage_stats.sv -----
// item_histogram_coverage_stats: histogram of item ids with coverage, entropy and gini readout
// depends on ihcs_pkg; one histogram memory, one shared multiplier and one serial divider
//
// A count command (command = 0) does one read and one write of the histogram entry; an
// id at or above the item count in use is dropped in the accepting cycle. A finish
// command walks the histogram several times; its gini pass sweeps the whole histogram
// once per covered item, and each covered item also goes through the shared base-2
// logarithm unit (normalising shifts and 26 squaring steps). The serial divider is DVD_W
// bits wide (67 at the default sizes). An empty histogram ends after the coverage sweep
// and one divide. The result is shown for one cycle with done high and cannot be held
// off. After it, and after reset, the histogram is cleared one entry a cycle while busy
// stays high.
// item_count may be written at any time the block is not busy.
module item_histogram_coverage_stats
	import ihcs_pkg::*;
#(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [ICNT_W-1:0]  cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [ID_W-1:0]    item_id,
	output logic               done,
	output logic [COV_W-1:0]   covered_items,
	output logic [RATIO_W-1:0] coverage_ratio,
	output logic [ENT_W-1:0]   entropy,
	output logic [GINI_W-1:0]  gini_index,
	output logic               empty_flag
);

	localparam int ADDR_W  = $clog2(MAX_ITEMS);
	localparam int ITEM_W  = ($clog2(MAX_ITEMS + 1) > ICNT_W) ? $clog2(MAX_ITEMS + 1) : ICNT_W;
	localparam int SUM_W   = COUNT_BITS + ITEM_W;
	localparam int LOGIN_W = (SUM_W > 32) ? SUM_W : 32;
	localparam int PW      = LOGIN_W + 32;
	localparam int GD_W    = 2 * ITEM_W + COUNT_BITS;
	localparam int DVS_W   = SUM_W + ITEM_W;
	localparam int DVD_W   = ((SUM_W + 32) > (GD_W + 16)) ? (SUM_W + 32) : (GD_W + 16);
	localparam int DCNT_W  = $clog2(DVD_W + 1);
	localparam int LE_W    = $clog2(LOGIN_W);

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_CWR, ST_SUM, ST_DIV, ST_LGN, ST_LGS,
		ST_ERD, ST_EDAT, ST_EMUL, ST_EACC, ST_HB, ST_ENT, ST_DEN,
		ST_GORD, ST_GOD, ST_GIN
	} state_t;

	typedef enum logic [1:0] {DV_RATIO, DV_ENT, DV_GINI} div_sel_t;
	typedef enum logic {LR_SUM, LR_ENT} lg_ret_t;

	state_t   state_q;
	div_sel_t dv_sel_q;
	lg_ret_t  lg_ret_q;

	logic [COUNT_BITS-1:0] mem_q [MAX_ITEMS];
	logic [COUNT_BITS-1:0] rd_data_q;
	logic                  mem_re, mem_we;
	logic [ADDR_W-1:0]     mem_raddr, mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;

	logic [ICNT_W-1:0] item_count_q;
	logic [ITEM_W-1:0] ic_ext, n, id_ext;
	logic [ITEM_W-1:0] sw_idx_q, oi_q, cov_q;
	logic              rv_q;
	logic [ADDR_W-1:0] cid_q;
	logic [SUM_W-1:0]  s_q;
	logic [DVD_W-1:0]  a_q;
	logic [GD_W-1:0]   d_q;
	logic [COUNT_BITS-1:0] f_q;
	logic [31:0]       ls_q;
	logic [PW-1:0]     prod_q;

	logic [LOGIN_W-1:0] nrm_q;
	logic [LE_W-1:0]    lg_e_q;
	logic [31:0]        m_q, lg_r_q;
	logic [4:0]         lg_i_q;

	logic [DVD_W-1:0]  dv_dvd_q;
	logic [DVS_W-1:0]  dv_den_q, dv_rem_q, rem_next;
	logic [DCNT_W-1:0] dv_cnt_q;
	logic [DVS_W:0]    r2, r_sub;
	logic              dv_ge;

	logic [LOGIN_W-1:0] mul_a;
	logic [31:0]        mul_b;
	logic [PW-1:0]      mul_p;
	logic [32:0]        sq;

	logic [31:0]       hb;
	logic [64:0]       esum;
	logic [22:0]       ent23;
	logic              rnd;
	logic [DVD_W:0]    qr;
	logic [GINI_W-1:0] gini_v;
	logic              sweep_issue;

	logic               done_q, empty_q;
	logic [COV_W-1:0]   cov_out_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [ENT_W-1:0]   ent_q;
	logic [GINI_W-1:0]  gini_q;

	assign ic_ext = ITEM_W'(item_count_q);
	assign n = (ic_ext < ITEM_W'(2)) ? ITEM_W'(2) :
		(ic_ext > ITEM_W'(MAX_ITEMS)) ? ITEM_W'(MAX_ITEMS) : ic_ext;
	assign id_ext = ITEM_W'(item_id);
	assign sweep_issue = sw_idx_q < n;

	// histogram memory ports
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = sw_idx_q[ADDR_W-1:0];
		mem_we    = 1'b0;
		mem_waddr = sw_idx_q[ADDR_W-1:0];
		mem_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				mem_re    = start && (command == CMD_COUNT);
				mem_raddr = id_ext[ADDR_W-1:0];
			end
			ST_SUM, ST_GIN: begin
				mem_re = sweep_issue;
			end
			ST_ERD, ST_GORD: begin
				mem_re    = oi_q < n;
				mem_raddr = oi_q[ADDR_W-1:0];
			end
			ST_CWR: begin
				mem_we    = rd_data_q != '1;
				mem_waddr = cid_q;
				mem_wdata = rd_data_q + COUNT_BITS'(1);
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem_q[mem_raddr];
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_LGS: begin
				mul_a = LOGIN_W'(m_q);
				mul_b = m_q;
			end
			ST_EMUL: begin
				mul_a = LOGIN_W'(f_q);
				mul_b = lg_r_q;
			end
			ST_HB: begin
				mul_a = LOGIN_W'(hb);
				mul_b = LN2_Q32;
			end
			ST_DEN: begin
				mul_a = LOGIN_W'(s_q);
				mul_b = 32'(n - ITEM_W'(1));
			end
			default: ;
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);
	assign sq    = mul_p[63:31];

	// serial divider step
	assign r2       = {dv_rem_q, dv_dvd_q[DVD_W-1]};
	assign r_sub    = r2 - {1'b0, dv_den_q};
	assign dv_ge    = r2 >= {1'b0, dv_den_q};
	assign rem_next = dv_ge ? r_sub[DVS_W-1:0] : r2[DVS_W-1:0];

	assign hb    = (DVD_W'(ls_q) > dv_dvd_q) ? (ls_q - dv_dvd_q[31:0]) : 32'd0;
	assign esum  = {1'b0, prod_q[63:0]} + (65'd1 << 41);
	assign ent23 = esum[64:42];
	assign rnd   = dv_rem_q >= (dv_den_q - dv_rem_q);
	assign qr    = {1'b0, dv_dvd_q} + (DVD_W + 1)'(rnd);
	assign gini_v = (qr > (DVD_W + 1)'(GINI_ONE)) ? GINI_ONE : qr[GINI_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			item_count_q <= ITEM_COUNT_RESET;
			sw_idx_q     <= '0;
			rv_q         <= 1'b0;
			done_q       <= 1'b0;
			dv_sel_q     <= DV_RATIO;
			lg_ret_q     <= LR_SUM;
		end else begin
			if (cfg_we) item_count_q <= cfg_wdata;
			case (state_q)
				ST_CLR: begin
					done_q   <= 1'b0;
					sw_idx_q <= sw_idx_q + ITEM_W'(1);
					if (sw_idx_q == ITEM_W'(MAX_ITEMS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						if (command == CMD_COUNT) begin
							cid_q <= id_ext[ADDR_W-1:0];
							if (id_ext < n) state_q <= ST_CWR;
						end else begin
							sw_idx_q <= '0;
							rv_q     <= 1'b0;
							s_q      <= '0;
							cov_q    <= '0;
							state_q  <= ST_SUM;
						end
					end
				end
				ST_CWR: begin
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					rv_q <= sweep_issue;
					if (rv_q) begin
						s_q <= s_q + SUM_W'(rd_data_q);
						if (rd_data_q != '0) cov_q <= cov_q + ITEM_W'(1);
					end
					if (sweep_issue) begin
						sw_idx_q <= sw_idx_q + ITEM_W'(1);
					end else if (!rv_q) begin
						dv_dvd_q <= (DVD_W'(cov_q) << 17) + DVD_W'(n);
						dv_den_q <= DVS_W'({n, 1'b0});
						dv_rem_q <= '0;
						dv_cnt_q <= DCNT_W'(DVD_W);
						dv_sel_q <= DV_RATIO;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dv_cnt_q != '0) begin
						dv_dvd_q <= {dv_dvd_q[DVD_W-2:0], dv_ge};
						dv_rem_q <= rem_next;
						dv_cnt_q <= dv_cnt_q - DCNT_W'(1);
					end else begin
						case (dv_sel_q)
							DV_RATIO: begin
								ratio_q   <= dv_dvd_q[RATIO_W-1:0];
								cov_out_q <= (cov_q > ITEM_W'(COV_MAX)) ? COV_MAX
									: cov_q[COV_W-1:0];
								if (s_q == '0) begin
									ent_q   <= '0;
									gini_q  <= '0;
									empty_q <= 1'b1;
									done_q  <= 1'b1;
									sw_idx_q <= '0;
									state_q <= ST_CLR;
								end else begin
									nrm_q    <= LOGIN_W'(s_q);
									lg_e_q   <= LE_W'(LOGIN_W - 1);
									lg_ret_q <= LR_SUM;
									state_q  <= ST_LGN;
								end
							end
							DV_ENT: begin
								state_q <= ST_HB;
							end
							default: begin
								gini_q   <= gini_v;
								empty_q  <= 1'b0;
								done_q   <= 1'b1;
								sw_idx_q <= '0;
								state_q  <= ST_CLR;
							end
						endcase
					end
				end
				ST_LGN: begin
					if (nrm_q[LOGIN_W-1]) begin
						m_q     <= nrm_q[LOGIN_W-1 -: 32];
						lg_r_q  <= 32'(lg_e_q) << LOG_FRAC;
						lg_i_q  <= 5'(LOG_FRAC - 1);
						state_q <= ST_LGS;
					end else begin
						nrm_q  <= nrm_q << 1;
						lg_e_q <= lg_e_q - LE_W'(1);
					end
				end
				ST_LGS: begin
					if (sq[32]) begin
						m_q            <= sq[32:1];
						lg_r_q[lg_i_q] <= 1'b1;
					end else begin
						m_q <= sq[31:0];
					end
					lg_i_q <= lg_i_q - 5'd1;
					if (lg_i_q == '0) begin
						if (lg_ret_q == LR_SUM) begin
							state_q <= ST_ERD;
						end else begin
							state_q <= ST_EMUL;
						end
					end
				end
				ST_ERD: begin
					if (lg_ret_q == LR_SUM) begin
						// first entry of the entropy pass
						ls_q     <= lg_r_q;
						lg_ret_q <= LR_ENT;
						oi_q     <= '0;
						a_q      <= '0;
					end else if (oi_q < n) begin
						state_q <= ST_EDAT;
					end else begin
						dv_dvd_q <= a_q;
						dv_den_q <= DVS_W'(s_q);
						dv_rem_q <= '0;
						dv_cnt_q <= DCNT_W'(DVD_W);
						dv_sel_q <= DV_ENT;
						state_q  <= ST_DIV;
					end
				end
				ST_EDAT: begin
					f_q <= rd_data_q;
					if (rd_data_q != '0) begin
						nrm_q   <= LOGIN_W'(rd_data_q);
						lg_e_q  <= LE_W'(LOGIN_W - 1);
						state_q <= ST_LGN;
					end else begin
						oi_q    <= oi_q + ITEM_W'(1);
						state_q <= ST_ERD;
					end
				end
				ST_EMUL: begin
					prod_q  <= mul_p;
					state_q <= ST_EACC;
				end
				ST_EACC: begin
					a_q     <= a_q + DVD_W'(prod_q);
					oi_q    <= oi_q + ITEM_W'(1);
					state_q <= ST_ERD;
				end
				ST_HB: begin
					prod_q  <= mul_p;
					state_q <= ST_ENT;
				end
				ST_ENT: begin
					ent_q   <= (ent23 > 23'(ENT_MAX)) ? ENT_MAX : ent23[ENT_W-1:0];
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					dv_den_q <= mul_p[DVS_W-1:0];
					oi_q     <= '0;
					d_q      <= '0;
					state_q  <= ST_GORD;
				end
				ST_GORD: begin
					if (oi_q < n) begin
						state_q <= ST_GOD;
					end else begin
						dv_dvd_q <= DVD_W'(d_q) << 16;
						dv_rem_q <= '0;
						dv_cnt_q <= DCNT_W'(DVD_W);
						dv_sel_q <= DV_GINI;
						state_q  <= ST_DIV;
					end
				end
				ST_GOD: begin
					f_q <= rd_data_q;
					if (rd_data_q != '0) begin
						sw_idx_q <= '0;
						rv_q     <= 1'b0;
						state_q  <= ST_GIN;
					end else begin
						oi_q    <= oi_q + ITEM_W'(1);
						state_q <= ST_GORD;
					end
				end
				ST_GIN: begin
					rv_q <= sweep_issue;
					if (rv_q && (f_q > rd_data_q)) begin
						d_q <= d_q + GD_W'(f_q - rd_data_q);
					end
					if (sweep_issue) begin
						sw_idx_q <= sw_idx_q + ITEM_W'(1);
					end else if (!rv_q) begin
						oi_q    <= oi_q + ITEM_W'(1);
						state_q <= ST_GORD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign covered_items  = cov_out_q;
	assign coverage_ratio = ratio_q;
	assign entropy        = ent_q;
	assign gini_index     = gini_q;
	assign empty_flag     = empty_q;

endmodule
